// ===== src/bbd_pkg.sv =====
// Package with shared types and constants for the Bayer demosaic block.
`timescale 1ns / 1ps
package bbd_pkg;
    localparam int MaxWidth  = 4096;
    localparam int ColBits   = $clog2(MaxWidth);
    localparam int PixBits   = 16;
    localparam int OutBits   = 18;
    localparam int DimBits   = 13;
    // One bit above the sizes, as the input row runs past the last row while flushing.
    localparam int CntBits   = 14;
    localparam int AddrBits  = 4;

    localparam logic [1:0] RegWidth  = 2'd0;
    localparam logic [1:0] RegHeight = 2'd1;
    localparam logic [1:0] RegRowPh  = 2'd2;
    localparam logic [1:0] RegColPh  = 2'd3;

    // Classified request handed from the front to the back part.
    typedef struct packed {
        logic [PixBits-1:0] win_tl, win_tc, win_tr;
        logic [PixBits-1:0] win_ml, win_mc, win_mr;
        logic [PixBits-1:0] win_bl, win_bc, win_br;
        logic               red_row;
        logic               red_col;
        logic               eof;
    } t_job;
endpackage

// ===== src/bbd_front.sv =====
// Front part: line stores, 3x3 window, counters and border selection.
`timescale 1ns / 1ps
module bbd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_req_type,
    input  logic [15:0]         i_pixel,
    input  logic [12:0]         i_width,
    input  logic [12:0]         i_height,
    input  logic                i_row_phase,
    input  logic                i_col_phase,
    output logic                o_job_valid,
    output bbd_pkg::t_job       o_job
);
    import bbd_pkg::*;

    logic [PixBits-1:0] r_store_a [MaxWidth];
    logic [PixBits-1:0] r_store_b [MaxWidth];
    logic [PixBits-1:0] r_win [9];
    logic [CntBits-1:0] r_in_col, r_in_row, r_out_col, r_out_row;
    logic [CntBits-1:0] n_in_col, n_in_row, n_out_col, n_out_row;
    // Second stage: the request taken at the previous edge and its line store data.
    logic               r_s2_valid, r_s2_emit, r_s2_eof, r_s2_red_row, r_s2_red_col;
    logic               r_s2_bypass;
    logic [ColBits-1:0] r_s2_col;
    logic [PixBits-1:0] r_s2_sample, r_rd_a, r_rd_b, r_fwd_a, r_fwd_b;
    logic [3:0]         r_s2_tbase, r_s2_bbase, r_s2_lc, r_s2_rc;
    logic [CntBits-1:0] w, h;
    logic [ColBits-1:0] col;
    logic flushing, drain, step, emit, eof, bypass;
    logic [PixBits-1:0] sample, top, mid;
    logic [PixBits-1:0] win_n [9];
    logic [3:0] tbase, bbase, lc, rc;

    always_comb begin
        w = (i_width == '0) ? CntBits'(1) : CntBits'(i_width);
        if (w > CntBits'(MaxWidth)) w = CntBits'(MaxWidth);
        h = (i_height == '0) ? CntBits'(1) : CntBits'(i_height);
        flushing = r_in_row >= h;
        drain = i_req_type;
        step = i_valid && !(drain && !flushing);
        sample = flushing ? '0 : i_pixel;
        col = (r_in_col < w) ? r_in_col[ColBits-1:0] : ColBits'(w - 1'b1);
        emit = (r_in_row >= CntBits'(2))
            || (r_in_row == CntBits'(1) && r_in_col >= CntBits'(1));
        n_in_col = r_in_col + 1'b1;
        n_in_row = r_in_row;
        if (n_in_col >= w) begin
            n_in_col = '0;
            n_in_row = r_in_row + 1'b1;
        end
        eof = (r_out_row + 1'b1 >= h) && (r_out_col + 1'b1 >= w);
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (emit) begin
            if (eof) begin
                n_in_col = '0; n_in_row = '0; n_out_col = '0; n_out_row = '0;
            end else begin
                n_out_col = r_out_col + 1'b1;
                if (n_out_col >= w) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 1'b1;
                end
            end
        end
        // Window indices folded at the borders so that edge pixels repeat.
        lc    = (r_out_col == '0) ? 4'd1 : 4'd0;
        rc    = (r_out_col + 1'b1 >= w) ? 4'd1 : 4'd2;
        tbase = (r_out_row == '0) ? 4'd3 : 4'd0;
        bbase = (r_out_row + 1'b1 >= h) ? 4'd3 : 4'd6;
        // The second stage writes its column at this same edge, so a read of
        // that column must take the values being written instead.
        bypass = r_s2_valid && (r_s2_col == col);
    end

    always_comb begin
        top = r_s2_bypass ? r_fwd_a : r_rd_a;
        mid = r_s2_bypass ? r_fwd_b : r_rd_b;
        for (int k = 0; k < 3; k++) begin
            win_n[k*3]   = r_win[k*3+1];
            win_n[k*3+1] = r_win[k*3+2];
        end
        win_n[2] = top;
        win_n[5] = mid;
        win_n[8] = r_s2_sample;
    end

    // Line stores: a registered read in the first stage, the write in the second.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_rd_a <= r_store_a[col];
            r_rd_b <= r_store_b[col];
        end
        if (r_s2_valid) begin
            r_store_a[r_s2_col] <= mid;
            r_store_b[r_s2_col] <= r_s2_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) r_win[k] <= '0;
            r_in_col <= '0; r_in_row <= '0; r_out_col <= '0; r_out_row <= '0;
            r_s2_valid <= 1'b0;
            o_job_valid <= 1'b0;
        end else begin
            r_s2_valid <= step;
            o_job_valid <= r_s2_valid && r_s2_emit;
            if (step) begin
                r_in_col <= n_in_col; r_in_row <= n_in_row;
                r_out_col <= n_out_col; r_out_row <= n_out_row;
            end
            if (r_s2_valid) begin
                for (int k = 0; k < 9; k++) r_win[k] <= win_n[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_s2_col     <= col;
            r_s2_sample  <= sample;
            r_s2_emit    <= emit;
            r_s2_eof     <= eof;
            r_s2_tbase   <= tbase;
            r_s2_bbase   <= bbase;
            r_s2_lc      <= lc;
            r_s2_rc      <= rc;
            r_s2_red_row <= r_out_row[0] == i_row_phase;
            r_s2_red_col <= r_out_col[0] == i_col_phase;
            r_s2_bypass  <= bypass;
            r_fwd_a      <= mid;
            r_fwd_b      <= r_s2_sample;
        end
        if (r_s2_valid && r_s2_emit) begin
            o_job.win_tl  <= win_n[r_s2_tbase + r_s2_lc];
            o_job.win_tc  <= win_n[r_s2_tbase + 4'd1];
            o_job.win_tr  <= win_n[r_s2_tbase + r_s2_rc];
            o_job.win_ml  <= win_n[4'd3 + r_s2_lc];
            o_job.win_mc  <= win_n[4'd4];
            o_job.win_mr  <= win_n[4'd3 + r_s2_rc];
            o_job.win_bl  <= win_n[r_s2_bbase + r_s2_lc];
            o_job.win_bc  <= win_n[r_s2_bbase + 4'd1];
            o_job.win_br  <= win_n[r_s2_bbase + r_s2_rc];
            o_job.red_row <= r_s2_red_row;
            o_job.red_col <= r_s2_red_col;
            o_job.eof     <= r_s2_eof;
        end
    end
endmodule

// ===== src/bbd_back.sv =====
// Back part: interpolation sums and the result queue.
`timescale 1ns / 1ps
module bbd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  bbd_pkg::t_job       i_job,
    input  logic                i_pop,
    output logic                o_almost_full,
    output logic                o_empty,
    output logic [17:0]         o_blue,
    output logic [17:0]         o_green,
    output logic [17:0]         o_red,
    output logic                o_end_of_frame
);
    import bbd_pkg::*;

    localparam int Depth = 4;
    logic [OutBits*3:0] r_q [Depth];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [OutBits-1:0] ctr4, lr, tb, xs, plus, rv, gv, bv;
    logic do_pop;

    always_comb begin
        ctr4 = {i_job.win_mc, 2'b00};
        lr   = {{1'b0, i_job.win_ml} + {1'b0, i_job.win_mr}, 1'b0};
        tb   = {{1'b0, i_job.win_tc} + {1'b0, i_job.win_bc}, 1'b0};
        xs   = OutBits'(i_job.win_tl) + OutBits'(i_job.win_tr)
             + OutBits'(i_job.win_bl) + OutBits'(i_job.win_br);
        plus = OutBits'(i_job.win_ml) + OutBits'(i_job.win_mr)
             + OutBits'(i_job.win_tc) + OutBits'(i_job.win_bc);
        if (i_job.red_row && i_job.red_col) begin
            rv = ctr4; gv = plus; bv = xs;
        end else if (i_job.red_row) begin
            rv = lr; gv = ctr4; bv = tb;
        end else if (i_job.red_col) begin
            rv = tb; gv = ctr4; bv = lr;
        end else begin
            rv = xs; gv = plus; bv = ctr4;
        end
    end

    assign do_pop = i_pop && (r_cnt != '0);
    assign o_empty = (r_cnt == '0);
    // Two requests may still be in the front pipeline besides the one being taken.
    assign o_almost_full = (r_cnt >= 3'(Depth - 2));
    assign {o_end_of_frame, o_blue, o_green, o_red} = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_job_valid) r_q[r_wp] <= {i_job.eof, bv, gv, rv};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_job_valid) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + 3'(i_job_valid) - 3'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 3'(Depth) |-> !i_job_valid) else $error("result queue overflow");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(Depth)) else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 3'(Depth) |-> 2'(r_wp - r_rp) == r_cnt[1:0])
        else $error("queue pointers disagree with count");
endmodule

// ===== src/bayer_bilinear_demosaic.sv =====
// Top level of the bilinear Bayer demosaic block.
`timescale 1ns / 1ps
// Usage:
// Raw Bayer samples enter in raster order through a queue-like port: a
// request is taken when i_push is high and o_full is low. A drain request
// (i_req_type high) carries no sample; after the frame's last pixel it
// flushes the final row, and inside the frame it is dropped.
// Each result (blue, green, red in quarter units and an end-of-frame flag)
// waits on the output ports while o_empty is low and leaves on i_pop.
// The result for pixel n is produced by the request at position n+W+1; it
// passes the second stage and the job register, is then written into the
// result queue and can be popped from the cycle that follows.
// Throughput is one request per cycle while o_full is low: each line store
// takes one registered read and one write per cycle, with a bypass when both
// hit the same column. When the receiver stalls, the four-entry result
// queue fills and o_full rises with room still left for the requests in the
// front pipeline. Reset clears counters, window and queue; the line stores
// are not cleared, since border repetition keeps stale entries out of every
// result. Configuration is written over the APB port while the block is idle.
module bayer_bilinear_demosaic (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic                         i_req_type,
    input  logic [15:0]                  i_pixel,
    output logic                         o_empty,
    input  logic                         i_pop,
    output logic [17:0]                  o_blue,
    output logic [17:0]                  o_green,
    output logic [17:0]                  o_red,
    output logic                         o_end_of_frame,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bbd_pkg::AddrBits-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import bbd_pkg::*;

    logic [DimBits-1:0] r_width, r_height;
    logic r_row_phase, r_col_phase;
    logic job_valid, almost_full;
    t_job job;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign o_full = almost_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= 13'd4096; r_height <= 13'd4096;
            r_row_phase <= 1'b0; r_col_phase <= 1'b0;
        end else if (wr) begin
            unique case (paddr[3:2])
                RegWidth:  r_width <= pwdata[12:0];
                RegHeight: r_height <= pwdata[12:0];
                RegRowPh:  r_row_phase <= pwdata[0];
                RegColPh:  r_col_phase <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            RegWidth:  prdata = {19'd0, r_width};
            RegHeight: prdata = {19'd0, r_height};
            RegRowPh:  prdata = {31'd0, r_row_phase};
            RegColPh:  prdata = {31'd0, r_col_phase};
            default:   prdata = '0;
        endcase
    end

    bbd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_push && !o_full), .i_req_type(i_req_type), .i_pixel(i_pixel),
        .i_width(r_width), .i_height(r_height),
        .i_row_phase(r_row_phase), .i_col_phase(r_col_phase),
        .o_job_valid(job_valid), .o_job(job)
    );

    bbd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .i_job(job), .i_pop(i_pop),
        .o_almost_full(almost_full), .o_empty(o_empty),
        .o_blue(o_blue), .o_green(o_green), .o_red(o_red),
        .o_end_of_frame(o_end_of_frame)
    );
endmodule
